@@ design/subs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subs_pkg
// Types shared by the sorted-table upper-bound search core.
// ----------------------------------------------------------------------------
package subs_pkg;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic [10:0] found_index;
        logic        not_found;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic search_load;
        logic entry_write;
        logic probe;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_dp_status;

    localparam logic [2:0] CFG_ADDR_ENTRIES_IN_USE = 3'd0;

endpackage

@@ design/subs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subs_ctrl
// Sequencer: accepts a beat, steps the probe loop and strobes the result.
// ----------------------------------------------------------------------------
module subs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  subs_pkg::t_op        i_op,
    input  subs_pkg::t_dp_status i_status,
    output subs_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_done
);

    subs_pkg::t_state r_state;
    subs_pkg::t_state n_state;
    logic             accept;

    assign accept = i_start && (r_state == subs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= subs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            subs_pkg::ST_IDLE: begin
                if (accept && i_op == subs_pkg::OP_SEARCH) begin
                    n_state = i_status.empty ? subs_pkg::ST_DONE : subs_pkg::ST_PROBE;
                end
            end
            subs_pkg::ST_PROBE: begin
                if (i_status.last) begin
                    n_state = subs_pkg::ST_DONE;
                end
            end
            subs_pkg::ST_DONE: begin
                n_state = subs_pkg::ST_IDLE;
            end
            default: begin
                n_state = subs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.search_load = 1'b0;
        o_cmd.entry_write = 1'b0;
        o_cmd.probe       = 1'b0;
        o_busy            = 1'b1;
        o_done            = 1'b0;
        case (r_state)
            subs_pkg::ST_IDLE: begin
                o_busy            = 1'b0;
                o_cmd.search_load = accept && (i_op == subs_pkg::OP_SEARCH);
                o_cmd.entry_write = accept && (i_op == subs_pkg::OP_WRITE);
            end
            subs_pkg::ST_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            subs_pkg::ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

@@ design/subs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subs_dp
// Table memory, search bounds and probe compare.
// ----------------------------------------------------------------------------
module subs_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  subs_pkg::t_dp_cmd    i_cmd,
    input  subs_pkg::t_in_item   i_item,
    input  logic [10:0]          i_entries_in_use,
    output subs_pkg::t_dp_status o_status,
    output subs_pkg::t_out_item  o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

    logic signed [31:0] r_mem [TABLE_DEPTH];
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_key;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_hi;
    logic [CW-1:0]      r_mid;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_lo;
    logic [CW-1:0]      n_hi;
    logic [CW-1:0]      n_mid;
    logic [CW-1:0]      sat_count;
    logic [CW-1:0]      lo_b;
    logic [CW-1:0]      mid_a;
    logic [CW-1:0]      mid_b;
    logic [31:0]        cnt32;
    logic [31:0]        sat32;
    logic [31:0]        idx32;
    logic [31:0]        lo32;
    logic               gt;

    assign cnt32     = {21'd0, i_entries_in_use};
    assign sat32     = (cnt32 > DEPTH32) ? DEPTH32 : cnt32;
    assign sat_count = sat32[CW-1:0];
    assign idx32     = {22'd0, i_item.entry_index};

    assign gt    = r_key < r_rd_data;
    assign lo_b  = r_mid + CW'(1);
    assign mid_a = r_lo + ((r_mid - r_lo) >> 1);
    assign mid_b = lo_b + ((r_hi - lo_b) >> 1);

    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_mid = r_mid;
        if (i_cmd.search_load) begin
            n_lo  = '0;
            n_hi  = sat_count;
            n_mid = sat_count >> 1;
        end else if (i_cmd.probe) begin
            if (gt) begin
                n_hi  = r_mid;
                n_mid = mid_a;
            end else begin
                n_lo  = lo_b;
                n_mid = mid_b;
            end
        end
    end

    assign o_status.empty = (sat_count == '0);
    assign o_status.last  = (n_lo == n_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.entry_write && (idx32 < DEPTH32)) begin
            r_mem[idx32[AW-1:0]] <= i_item.entry_value;
        end
        r_rd_data <= r_mem[n_mid[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        if (i_cmd.search_load) begin
            r_key   <= i_item.search_key;
            r_count <= sat_count;
        end
    end

    assign lo32                 = 32'(r_lo);
    assign o_result.found_index = lo32[10:0];
    assign o_result.not_found   = (r_lo == r_count);

endmodule

@@ design/sorted_table_upper_bound_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_upper_bound_search_core
// Upper-bound binary search over a software-sorted table of signed entries.
// ----------------------------------------------------------------------------
// A write beat stores one entry in the accepting cycle and leaves busy low,
// so writes can go back to back. A search beat raises busy and makes one
// probe per cycle into the table memory, at most floor(log2(count)) + 1
// probes, then strobes o_done for one cycle with the result. The result is
// valid only in the o_done cycle and must be captured then; the receiver
// cannot stall it. The next beat may start in the cycle after o_done.
// ----------------------------------------------------------------------------
module sorted_table_upper_bound_search_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  subs_pkg::t_in_item  i_item,
    output logic                o_done,
    output subs_pkg::t_out_item o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    subs_pkg::t_dp_cmd    cmd;
    subs_pkg::t_dp_status status;
    logic [10:0]          r_entries_in_use;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr == subs_pkg::CFG_ADDR_ENTRIES_IN_USE);
    assign prdata = (paddr == subs_pkg::CFG_ADDR_ENTRIES_IN_USE)
                    ? {21'd0, r_entries_in_use} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (cfg_wr) begin
            r_entries_in_use <= pwdata[10:0];
        end
    end

    subs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_item.operation),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    subs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_item           (i_item),
        .i_entries_in_use (r_entries_in_use),
        .o_status         (status),
        .o_result         (o_result)
    );

endmodule
